// File: src/cbf_pkg.sv
// Package for the ChaCha block function unit: widths, beat types and round logic.
package cbf_pkg;

  localparam int MAX_ROUNDS  = 20;
  localparam int CELL_COUNT  = 2 * MAX_ROUNDS;
  localparam int WORD_W      = 32;
  localparam int WORD_COUNT  = 16;
  localparam int ROUND_CFG_W = 5;
  localparam int CNT_W       = $clog2(MAX_ROUNDS + 1);
  localparam int CMP_W       = (CNT_W > ROUND_CFG_W) ? CNT_W : ROUND_CFG_W;

  typedef logic [ROUND_CFG_W-1:0] round_cfg_t;
  typedef logic [CMP_W-1:0]       rcnt_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef word_t [WORD_COUNT-1:0] words_t;

  localparam round_cfg_t ROUND_RESET = round_cfg_t'(20);

  typedef struct packed {
    logic [63:0] state_words_0_1;
    logic [63:0] state_words_2_3;
    logic [63:0] state_words_4_5;
    logic [63:0] state_words_6_7;
    logic [63:0] state_words_8_9;
    logic [63:0] state_words_10_11;
    logic [63:0] state_words_12_13;
    logic [63:0] state_words_14_15;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] stream_words_0_1;
    logic [63:0] stream_words_2_3;
    logic [63:0] stream_words_4_5;
    logic [63:0] stream_words_6_7;
    logic [63:0] stream_words_8_9;
    logic [63:0] stream_words_10_11;
    logic [63:0] stream_words_12_13;
    logic [63:0] stream_words_14_15;
  } out_beat_t;

  // working state plus the original input, carried down the chain
  typedef struct packed {
    words_t work;
    words_t init;
  } stage_t;

  typedef struct packed {
    rcnt_t rounds;
    rcnt_t round_idx;
    logic  second_half;
  } cell_ctl_t;

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic words_t unpack_in(in_beat_t b);
    words_t w;
    w[0]  = b.state_words_0_1[31:0];
    w[1]  = b.state_words_0_1[63:32];
    w[2]  = b.state_words_2_3[31:0];
    w[3]  = b.state_words_2_3[63:32];
    w[4]  = b.state_words_4_5[31:0];
    w[5]  = b.state_words_4_5[63:32];
    w[6]  = b.state_words_6_7[31:0];
    w[7]  = b.state_words_6_7[63:32];
    w[8]  = b.state_words_8_9[31:0];
    w[9]  = b.state_words_8_9[63:32];
    w[10] = b.state_words_10_11[31:0];
    w[11] = b.state_words_10_11[63:32];
    w[12] = b.state_words_12_13[31:0];
    w[13] = b.state_words_12_13[63:32];
    w[14] = b.state_words_14_15[31:0];
    w[15] = b.state_words_14_15[63:32];
    return w;
  endfunction

  function automatic out_beat_t pack_out(words_t w);
    out_beat_t b;
    b.stream_words_0_1   = {w[1],  w[0]};
    b.stream_words_2_3   = {w[3],  w[2]};
    b.stream_words_4_5   = {w[5],  w[4]};
    b.stream_words_6_7   = {w[7],  w[6]};
    b.stream_words_8_9   = {w[9],  w[8]};
    b.stream_words_10_11 = {w[11], w[10]};
    b.stream_words_12_13 = {w[13], w[12]};
    b.stream_words_14_15 = {w[15], w[14]};
    return b;
  endfunction

  // Half of a column or diagonal round: first half rotates by 16/12, second by 8/7.
  function automatic words_t half_round(words_t w, logic diag, logic second);
    words_t r;
    int     ib;
    int     ic;
    int     id;
    word_t  va;
    word_t  vb;
    word_t  vc;
    word_t  vd;
    r = w;
    for (int q = 0; q < 4; q++) begin
      ib = diag ? 4  + ((q + 1) & 3) : 4  + q;
      ic = diag ? 8  + ((q + 2) & 3) : 8  + q;
      id = diag ? 12 + ((q + 3) & 3) : 12 + q;
      va = w[q] + w[ib];
      vd = w[id] ^ va;
      vd = second ? rotl(vd, 8) : rotl(vd, 16);
      vc = w[ic] + vd;
      vb = w[ib] ^ vc;
      vb = second ? rotl(vb, 7) : rotl(vb, 12);
      r[q]  = va;
      r[ib] = vb;
      r[ic] = vc;
      r[id] = vd;
    end
    return r;
  endfunction

endpackage

// File: src/cbf_cell.sv
// One half-round cell of the ChaCha round chain, with its own beat register.
module cbf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cbf_pkg::cell_ctl_t ctl,
  input  logic               up_valid,
  input  cbf_pkg::stage_t    up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output cbf_pkg::stage_t    dn_data,
  input  logic               dn_ready
);

  logic            valid_r;
  logic            valid_nxt;
  cbf_pkg::stage_t data_r;
  cbf_pkg::stage_t data_nxt;
  logic            active;

  always_comb begin
    active        = ctl.round_idx < ctl.rounds;
    data_nxt.init = up_data.init;
    data_nxt.work = active ?
                    cbf_pkg::half_round(up_data.work, ctl.round_idx[0], ctl.second_half) :
                    up_data.work;
    up_ready      = !valid_r || dn_ready;
    valid_nxt     = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: src/cbf_out_stage.sv
// Final feed-forward add and output register of the ChaCha block function unit.
module cbf_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  cbf_pkg::stage_t    up_data,
  output logic               up_ready,
  output logic               out_valid,
  output cbf_pkg::out_beat_t out_data,
  input  logic               out_stall
);

  logic               valid_r;
  logic               valid_nxt;
  cbf_pkg::out_beat_t data_r;
  cbf_pkg::out_beat_t data_nxt;
  cbf_pkg::words_t    sum;

  always_comb begin
    for (int i = 0; i < cbf_pkg::WORD_COUNT; i++) begin
      sum[i] = up_data.work[i] + up_data.init[i];
    end
    data_nxt  = cbf_pkg::pack_out(sum);
    up_ready  = !valid_r || !out_stall;
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: src/chacha_block_function_unit.sv
// Top level of the ChaCha block function unit: chain of half-round cells.
// Throughput: one block per cycle while out_stall is low; each round is two cells,
// each cell one register stage, followed by the output register.
// Cells past the configured round count pass their beat through unchanged.
// A stalled stage holds its beat; an empty stage upstream of it keeps accepting.
// Reset (rst_n low, synchronous) empties every stage and sets round_count to 20.
module chacha_block_function_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbf_pkg::ROUND_CFG_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cbf_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cbf_pkg::out_beat_t             out_data
);

  cbf_pkg::round_cfg_t round_count_r;
  cbf_pkg::round_cfg_t round_count_nxt;
  cbf_pkg::rcnt_t      rc_ext;
  cbf_pkg::rcnt_t      n_eff;

  logic            v   [cbf_pkg::CELL_COUNT+1];
  logic            rdy [cbf_pkg::CELL_COUNT+1];
  cbf_pkg::stage_t d   [cbf_pkg::CELL_COUNT+1];

  always_comb begin
    round_count_nxt = cfg_we ? cfg_wdata : round_count_r;
    rc_ext          = cbf_pkg::rcnt_t'(round_count_r);
    n_eff           = (rc_ext > cbf_pkg::rcnt_t'(cbf_pkg::MAX_ROUNDS)) ?
                      cbf_pkg::rcnt_t'(cbf_pkg::MAX_ROUNDS) : rc_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= cbf_pkg::ROUND_RESET;
    end else begin
      round_count_r <= round_count_nxt;
    end
  end

  assign v[0]      = in_valid;
  assign d[0].work = cbf_pkg::unpack_in(in_data);
  assign d[0].init = cbf_pkg::unpack_in(in_data);
  assign in_stall  = !rdy[0];

  for (genvar k = 0; k < cbf_pkg::CELL_COUNT; k++) begin : g_cell
    cbf_pkg::cell_ctl_t ctl;
    assign ctl.rounds      = n_eff;
    assign ctl.round_idx   = cbf_pkg::rcnt_t'(k / 2);
    assign ctl.second_half = 1'((k % 2));

    cbf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .up_valid (v[k]),
      .up_data  (d[k]),
      .up_ready (rdy[k]),
      .dn_valid (v[k+1]),
      .dn_data  (d[k+1]),
      .dn_ready (rdy[k+1])
    );
  end

  cbf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v[cbf_pkg::CELL_COUNT]),
    .up_data   (d[cbf_pkg::CELL_COUNT]),
    .up_ready  (rdy[cbf_pkg::CELL_COUNT]),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // empty output register frees the whole chain
  a_free_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_reset_rounds: assert property (@(posedge clk)
    !rst_n |=> round_count_r == cbf_pkg::ROUND_RESET)
    else $error("round count not restored by reset");

  a_rounds_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    n_eff <= cbf_pkg::rcnt_t'(cbf_pkg::MAX_ROUNDS))
    else $error("effective round count above maximum");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the ChaCha block function unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int  LATENCY     = 2 * cbf_pkg::MAX_ROUNDS + 1;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  RANDOM_PER_PHASE = 80;

  typedef logic [cbf_pkg::WORD_COUNT-1:0][31:0] block_words_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  cbf_pkg::round_cfg_t cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cbf_pkg::in_beat_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cbf_pkg::out_beat_t  out_data;

  cbf_pkg::in_beat_t   blocks_to_send[$];
  cbf_pkg::out_beat_t  keystream_due[$];
  cbf_pkg::round_cfg_t round_setting = cbf_pkg::ROUND_RESET;
  logic [31:0] settings_seen = '0;

  int blocks_sent;
  int blocks_checked;
  int mismatches;
  int cycles;
  int gap_left;
  int calm_in;
  int stall_left;
  int free_left;
  logic [31:0] block_ctr;
  logic [31:0] nonce_lo;

  chacha_block_function_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic block_words_t words_of(logic [511:0] flat);
    block_words_t w;
    for (int i = 0; i < 8; i++) begin
      w[2*i]   = flat[64*(7-i) +: 32];
      w[2*i+1] = flat[64*(7-i)+32 +: 32];
    end
    return w;
  endfunction

  function automatic logic [511:0] flat_of(block_words_t w);
    logic [511:0] flat;
    for (int i = 0; i < 8; i++)
      flat[64*(7-i) +: 64] = {w[2*i+1], w[2*i]};
    return flat;
  endfunction

  function automatic block_words_t mix_quarter(block_words_t w, int a, int b, int c, int d);
    w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic cbf_pkg::out_beat_t chacha_keystream(cbf_pkg::in_beat_t b,
                                                          cbf_pkg::round_cfg_t rounds);
    block_words_t seed;
    block_words_t w;
    int           n;
    seed = words_of(b);
    w    = seed;
    n    = (rounds > cbf_pkg::MAX_ROUNDS) ? cbf_pkg::MAX_ROUNDS : int'(rounds);
    for (int r = 0; r < n; r++) begin
      for (int q = 0; q < 4; q++) begin
        if (r % 2 == 0) begin
          w = mix_quarter(w, q, 4 + q, 8 + q, 12 + q);
        end else begin
          w = mix_quarter(w, q, 4 + (q + 1) % 4, 8 + (q + 2) % 4, 12 + (q + 3) % 4);
        end
      end
    end
    for (int i = 0; i < cbf_pkg::WORD_COUNT; i++)
      w[i] = w[i] + seed[i];
    return cbf_pkg::out_beat_t'(flat_of(w));
  endfunction

  function automatic int next_gap();
    int r;
    if (calm_in != 0) begin
      calm_in--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      calm_in = $urandom_range(5, 40);
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        keystream_due.push_back(chacha_keystream(in_data, round_setting));
        blocks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (blocks_to_send.size() != 0) begin
          in_data  <= blocks_to_send.pop_front();
          in_valid <= 1'b1;
          gap_left = next_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // result side
  always @(posedge clk) begin
    cbf_pkg::out_beat_t want;
    int                 r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (keystream_due.size() == 0) begin
          $error("output beat %h with no block outstanding", out_data);
          mismatches++;
        end else begin
          want = keystream_due.pop_front();
          compare_field("stream_words_0_1", want.stream_words_0_1, out_data.stream_words_0_1);
          compare_field("stream_words_2_3", want.stream_words_2_3, out_data.stream_words_2_3);
          compare_field("stream_words_4_5", want.stream_words_4_5, out_data.stream_words_4_5);
          compare_field("stream_words_6_7", want.stream_words_6_7, out_data.stream_words_6_7);
          compare_field("stream_words_8_9", want.stream_words_8_9, out_data.stream_words_8_9);
          compare_field("stream_words_10_11", want.stream_words_10_11,
                        out_data.stream_words_10_11);
          compare_field("stream_words_12_13", want.stream_words_12_13,
                        out_data.stream_words_12_13);
          compare_field("stream_words_14_15", want.stream_words_14_15,
                        out_data.stream_words_14_15);
          blocks_checked++;
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left != 0) begin
          free_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50)      free_left  = $urandom_range(5, 40);
          else if (r < 90) stall_left = $urandom_range(1, 3);
          else             stall_left = $urandom_range(10, 50);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic add_words(block_words_t w);
    blocks_to_send.push_back(cbf_pkg::in_beat_t'(flat_of(w)));
  endtask

  task automatic add_fill(logic [31:0] v);
    block_words_t w;
    for (int i = 0; i < cbf_pkg::WORD_COUNT; i++) w[i] = v;
    add_words(w);
  endtask

  // test vector state from the ChaCha20 spec (key 00..1f, counter 1)
  task automatic add_spec_state();
    add_words({32'h00000000, 32'h4a000000, 32'h09000000, 32'h00000001,
               32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110,
               32'h0f0e0d0c, 32'h0b0a0908, 32'h07060504, 32'h03020100,
               32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865});
  endtask

  task automatic wait_idle();
    while (blocks_to_send.size() != 0 || in_valid || keystream_due.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_rounds(cbf_pkg::round_cfg_t v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    round_setting = v;
    settings_seen[v] = 1'b1;
    @(negedge clk);
  endtask

  task automatic add_random(int count);
    block_words_t w;
    int           kind;
    nonce_lo = $urandom;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < cbf_pkg::WORD_COUNT; i++) w[i] = $urandom;
      if (kind < 6) begin
        // well-formed keystream request: constants, key, counter, nonce
        w[0]  = 32'h61707865;
        w[1]  = 32'h3320646e;
        w[2]  = 32'h79622d32;
        w[3]  = 32'h6b206574;
        w[12] = block_ctr;
        w[13] = nonce_lo;
        block_ctr++;
      end else if (kind == 9) begin
        for (int i = 0; i < cbf_pkg::WORD_COUNT; i++)
          case ($urandom_range(0, 2))
            0: w[i] = '0;
            1: w[i] = '1;
            default: ;
          endcase
      end
      add_words(w);
    end
  endtask

  initial begin
    block_words_t        w;
    cbf_pkg::round_cfg_t plan[10];
    settings_seen[cbf_pkg::ROUND_RESET] = 1'b1;
    block_ctr = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting, full 20 rounds
    add_fill(32'h00000000);
    add_fill(32'hffffffff);
    add_spec_state();
    add_fill(32'haaaaaaaa);
    add_fill(32'h55555555);
    add_fill(32'h80000000);
    w = '0; w[0] = 32'h1; add_words(w);
    w = '0; w[15] = 32'hffffffff; add_words(w);
    for (int i = 0; i < cbf_pkg::WORD_COUNT; i++) w[i] = (i % 2) ? 32'hffffffff : 32'h0;
    add_words(w);

    // zero rounds: output is twice the input
    set_rounds(cbf_pkg::round_cfg_t'(0));
    add_fill(32'h00000000);
    add_fill(32'hffffffff);
    add_fill(32'h80000000);
    add_spec_state();

    // above the maximum: saturates
    set_rounds(cbf_pkg::round_cfg_t'(31));
    add_spec_state();
    add_fill(32'hffffffff);

    set_rounds(cbf_pkg::round_cfg_t'(1));
    add_spec_state();
    add_fill(32'hffffffff);

    plan = '{cbf_pkg::round_cfg_t'(12), cbf_pkg::round_cfg_t'(8),
             cbf_pkg::round_cfg_t'(2), cbf_pkg::round_cfg_t'(21),
             cbf_pkg::round_cfg_t'(20), cbf_pkg::round_cfg_t'(0),
             cbf_pkg::round_cfg_t'(31), cbf_pkg::round_cfg_t'(1),
             cbf_pkg::round_cfg_t'($urandom_range(0, 31)),
             cbf_pkg::round_cfg_t'($urandom_range(0, 31))};
    foreach (plan[p]) begin
      set_rounds(plan[p]);
      add_random(RANDOM_PER_PHASE);
    end

    wait_idle();
    $display("Checked %0d of %0d keystream blocks across %0d round settings (0..31),",
             blocks_checked, blocks_sent, $countones(settings_seen));
    $display("with random input gaps and output stalls; %0d mismatches.", mismatches);
    if (mismatches == 0 && keystream_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
